### design/matrix_inverse_3x3_macros.svh
// Assertion helpers for the 3x3 matrix inverse checker.
// Both expect clk and rst_n to be visible where they are used.
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define MI3_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies an expression in the next.
`define MI3_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### design/mi3_pkg.sv
package mi3_pkg;

    // Nine matrix elements, listed column by column.
    localparam int NUM_ELEMS = 9;

    // The determinant is expanded along row 0.
    localparam int NUM_DET_TERMS = 3;

    // Register stages outside the quotient loop: input, two cofactor stages,
    // three determinant stages, magnitude stage, quotient setup and output.
    localparam int FIXED_STAGES = 9;

    // Cofactor k is elem[a] * elem[b] - elem[x] * elem[y].
    localparam int COF_IDX [NUM_ELEMS][4] = '{
        '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 3, 1}
    };

    // Row 0 elements that multiply the first three cofactors.
    localparam int DET_IDX [NUM_DET_TERMS] = '{0, 3, 6};

endpackage

### design/mi3_cofactor.sv
module mi3_cofactor
    import mi3_pkg::*;
#(
    parameter int ELEM_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic signed [ELEM_WIDTH-1:0]  elem [NUM_ELEMS],
    output logic signed [2*ELEM_WIDTH:0]  cof [NUM_ELEMS],
    output logic signed [ELEM_WIDTH-1:0]  det_elem [NUM_DET_TERMS]
);

    localparam int PW = 2 * ELEM_WIDTH;

    logic signed [PW-1:0]         prod_a_reg [NUM_ELEMS];
    logic signed [PW-1:0]         prod_b_reg [NUM_ELEMS];
    logic signed [PW:0]           cof_reg [NUM_ELEMS];
    logic signed [ELEM_WIDTH-1:0] row_d1_reg [NUM_DET_TERMS];
    logic signed [ELEM_WIDTH-1:0] row_d2_reg [NUM_DET_TERMS];

    // Both products of every cofactor are registered before the subtraction.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_ELEMS; k++)
        begin
            prod_a_reg[k] <= elem[COF_IDX[k][0]] * elem[COF_IDX[k][1]];
            prod_b_reg[k] <= elem[COF_IDX[k][2]] * elem[COF_IDX[k][3]];
            cof_reg[k]    <= (PW+1)'(prod_a_reg[k]) - (PW+1)'(prod_b_reg[k]);
        end
        for (int t = 0; t < NUM_DET_TERMS; t++)
        begin
            row_d1_reg[t] <= elem[DET_IDX[t]];
            row_d2_reg[t] <= row_d1_reg[t];
        end
    end

    assign cof      = cof_reg;
    assign det_elem = row_d2_reg;

endmodule

### design/mi3_determinant.sv
module mi3_determinant
    import mi3_pkg::*;
#(
    parameter int ELEM_WIDTH = 32
)
(
    input  logic                           clk,
    input  logic signed [2*ELEM_WIDTH:0]   cof [NUM_ELEMS],
    input  logic signed [ELEM_WIDTH-1:0]   det_elem [NUM_DET_TERMS],
    output logic signed [3*ELEM_WIDTH+2:0] det,
    output logic signed [2*ELEM_WIDTH:0]   cof_out [NUM_ELEMS]
);

    localparam int CW = 2 * ELEM_WIDTH + 1;
    localparam int PW = 2 * ELEM_WIDTH + 1;
    localparam int TW = 3 * ELEM_WIDTH + 1;
    localparam int DW = 3 * ELEM_WIDTH + 3;

    logic signed [ELEM_WIDTH:0] cof_hi [NUM_DET_TERMS];
    logic signed [ELEM_WIDTH:0] cof_lo [NUM_DET_TERMS];

    logic signed [PW-1:0] part_hi_reg [NUM_DET_TERMS];
    logic signed [PW-1:0] part_lo_reg [NUM_DET_TERMS];
    logic signed [TW-1:0] term_reg [NUM_DET_TERMS];
    logic signed [DW-1:0] det_reg;
    logic signed [CW-1:0] cof_d_reg [3][NUM_ELEMS];

    // Each of the first three cofactors is split so that no multiplier exceeds one
    // element width by one element width plus a sign bit.
    always_comb
    begin
        for (int t = 0; t < NUM_DET_TERMS; t++)
        begin
            cof_hi[t] = cof[t][CW-1:ELEM_WIDTH];
            cof_lo[t] = {1'b0, cof[t][ELEM_WIDTH-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int t = 0; t < NUM_DET_TERMS; t++)
        begin
            part_hi_reg[t] <= det_elem[t] * cof_hi[t];
            part_lo_reg[t] <= det_elem[t] * cof_lo[t];
            term_reg[t]    <= (TW'(part_hi_reg[t]) <<< ELEM_WIDTH) + TW'(part_lo_reg[t]);
        end
        det_reg <= DW'(term_reg[0]) + DW'(term_reg[1]) + DW'(term_reg[2]);
        for (int k = 0; k < NUM_ELEMS; k++)
        begin
            cof_d_reg[0][k] <= cof[k];
            cof_d_reg[1][k] <= cof_d_reg[0][k];
            cof_d_reg[2][k] <= cof_d_reg[1][k];
        end
    end

    assign det     = det_reg;
    assign cof_out = cof_d_reg[2];

endmodule

### design/mi3_divider.sv
module mi3_divider
    import mi3_pkg::*;
#(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                           clk,
    input  logic signed [2*ELEM_WIDTH:0]   cof [NUM_ELEMS],
    input  logic signed [3*ELEM_WIDTH+2:0] det,
    output logic signed [ELEM_WIDTH-1:0]   inv [NUM_ELEMS],
    output logic signed [ELEM_WIDTH-1:0]   det_value,
    output logic                           singular
);

    localparam int CW = 2 * ELEM_WIDTH + 1;
    localparam int DW = 3 * ELEM_WIDTH + 3;
    localparam int NW = CW + 2 * FRAC_BITS;
    localparam int HW = NW - ELEM_WIDTH;
    localparam int RW = ((DW > HW) ? DW : HW) + 1;
    localparam logic [ELEM_WIDTH-1:0] ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
    localparam logic [ELEM_WIDTH-1:0] ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};

    logic [CW-1:0]         cof_abs [NUM_ELEMS];
    logic signed [DW-1:0]  det_shift;
    logic [ELEM_WIDTH-1:0] det_sat;
    logic [RW-1:0]         shifted [ELEM_WIDTH][NUM_ELEMS];
    logic                  fits [ELEM_WIDTH][NUM_ELEMS];

    logic [NW-1:0]         num_reg [NUM_ELEMS];
    logic                  sign_reg [NUM_ELEMS];
    logic [DW-1:0]         dabs_reg;
    logic                  zero_reg;
    logic [ELEM_WIDTH-1:0] detv_reg;

    logic [RW-1:0]         rem_reg [ELEM_WIDTH+1][NUM_ELEMS];
    logic [ELEM_WIDTH-1:0] low_reg [ELEM_WIDTH+1][NUM_ELEMS];
    logic [ELEM_WIDTH-1:0] quo_reg [ELEM_WIDTH+1][NUM_ELEMS];
    logic                  ovf_reg [ELEM_WIDTH+1][NUM_ELEMS];
    logic                  neg_reg [ELEM_WIDTH+1][NUM_ELEMS];
    logic [DW-1:0]         div_reg [ELEM_WIDTH+1];
    logic                  sing_reg [ELEM_WIDTH+1];
    logic [ELEM_WIDTH-1:0] dval_reg [ELEM_WIDTH+1];

    logic [ELEM_WIDTH-1:0] inv_reg [NUM_ELEMS];
    logic [ELEM_WIDTH-1:0] det_out_reg;
    logic                  sing_out_reg;

    always_comb
    begin
        for (int k = 0; k < NUM_ELEMS; k++)
        begin
            cof_abs[k] = cof[k][CW-1] ? CW'(-cof[k]) : CW'(cof[k]);
        end
        det_shift = det >>> (2 * FRAC_BITS);
        if ((det_shift[DW-1:ELEM_WIDTH-1] != '0) && (det_shift[DW-1:ELEM_WIDTH-1] != '1))
        begin
            det_sat = det[DW-1] ? ELEM_MIN : ELEM_MAX;
        end
        else
        begin
            det_sat = det_shift[ELEM_WIDTH-1:0];
        end
    end

    // One restoring step per stage: shift in the next numerator bit and
    // subtract the divisor when it fits.
    always_comb
    begin
        for (int s = 0; s < ELEM_WIDTH; s++)
        begin
            for (int k = 0; k < NUM_ELEMS; k++)
            begin
                shifted[s][k] = {rem_reg[s][k][RW-2:0], low_reg[s][k][ELEM_WIDTH-1]};
                fits[s][k]    = shifted[s][k] >= RW'(div_reg[s]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // Magnitudes and signs.
        for (int k = 0; k < NUM_ELEMS; k++)
        begin
            num_reg[k]  <= {cof_abs[k], {(2*FRAC_BITS){1'b0}}};
            sign_reg[k] <= cof[k][CW-1] ^ det[DW-1];
        end
        dabs_reg <= det[DW-1] ? DW'(-det) : DW'(det);
        zero_reg <= (det == '0);
        detv_reg <= det_sat;

        // Quotient setup: the upper numerator part seeds the remainder, and a
        // quotient that cannot fit in one element width is flagged here.
        for (int k = 0; k < NUM_ELEMS; k++)
        begin
            rem_reg[0][k] <= RW'(num_reg[k][NW-1:ELEM_WIDTH]);
            low_reg[0][k] <= num_reg[k][ELEM_WIDTH-1:0];
            quo_reg[0][k] <= '0;
            ovf_reg[0][k] <= RW'(num_reg[k][NW-1:ELEM_WIDTH]) >= RW'(dabs_reg);
            neg_reg[0][k] <= sign_reg[k];
        end
        div_reg[0]  <= dabs_reg;
        sing_reg[0] <= zero_reg;
        dval_reg[0] <= detv_reg;

        for (int s = 0; s < ELEM_WIDTH; s++)
        begin
            for (int k = 0; k < NUM_ELEMS; k++)
            begin
                rem_reg[s+1][k] <= fits[s][k] ? shifted[s][k] - RW'(div_reg[s])
                                              : shifted[s][k];
                low_reg[s+1][k] <= {low_reg[s][k][ELEM_WIDTH-2:0], 1'b0};
                quo_reg[s+1][k] <= {quo_reg[s][k][ELEM_WIDTH-2:0], fits[s][k]};
                ovf_reg[s+1][k] <= ovf_reg[s][k];
                neg_reg[s+1][k] <= neg_reg[s][k];
            end
            div_reg[s+1]  <= div_reg[s];
            sing_reg[s+1] <= sing_reg[s];
            dval_reg[s+1] <= dval_reg[s];
        end

        // Sign, saturation and the singular override.
        for (int k = 0; k < NUM_ELEMS; k++)
        begin
            if (sing_reg[ELEM_WIDTH])
            begin
                inv_reg[k] <= '0;
            end
            else if (ovf_reg[ELEM_WIDTH][k] || quo_reg[ELEM_WIDTH][k][ELEM_WIDTH-1])
            begin
                inv_reg[k] <= neg_reg[ELEM_WIDTH][k] ? ELEM_MIN : ELEM_MAX;
            end
            else
            begin
                inv_reg[k] <= neg_reg[ELEM_WIDTH][k] ? -quo_reg[ELEM_WIDTH][k]
                                                     : quo_reg[ELEM_WIDTH][k];
            end
        end
        det_out_reg  <= sing_reg[ELEM_WIDTH] ? '0 : dval_reg[ELEM_WIDTH];
        sing_out_reg <= sing_reg[ELEM_WIDTH];
    end

    always_comb
    begin
        for (int k = 0; k < NUM_ELEMS; k++)
        begin
            inv[k] = inv_reg[k];
        end
    end

    assign det_value = det_out_reg;
    assign singular  = sing_out_reg;

endmodule

### design/matrix_inverse_3x3.sv
// 3x3 fixed-point matrix inverse by the adjugate, fully pipelined.
// Input channel: a matrix item (nine signed Q elements, column by column) is
// taken at every rising edge where start is high and busy is low. Busy is
// always low, so a new item may be presented in every cycle.
// Output channel: done is high for exactly one cycle per result while the nine inverse
// elements, the saturated determinant and the singular flag are valid.
// Throughput is one item per cycle. The quotient pipeline retires one quotient
// bit per stage over ELEM_WIDTH stages, with one compare and subtract in
// each. The other nine stages are the input register, two cofactor stages,
// three determinant stages, a magnitude stage, a quotient setup stage and
// the output register.
// Reset clears only the valid bits that travel beside the data; nothing is
// held between items. The receiver cannot stall, so results are never held
// back and each item produces exactly one result.
module matrix_inverse_3x3
    import mi3_pkg::*;
#(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [ELEM_WIDTH-1:0] a_r0c0,
    input  logic signed [ELEM_WIDTH-1:0] a_r1c0,
    input  logic signed [ELEM_WIDTH-1:0] a_r2c0,
    input  logic signed [ELEM_WIDTH-1:0] a_r0c1,
    input  logic signed [ELEM_WIDTH-1:0] a_r1c1,
    input  logic signed [ELEM_WIDTH-1:0] a_r2c1,
    input  logic signed [ELEM_WIDTH-1:0] a_r0c2,
    input  logic signed [ELEM_WIDTH-1:0] a_r1c2,
    input  logic signed [ELEM_WIDTH-1:0] a_r2c2,
    output logic                         done,
    output logic signed [ELEM_WIDTH-1:0] inv_r0c0,
    output logic signed [ELEM_WIDTH-1:0] inv_r1c0,
    output logic signed [ELEM_WIDTH-1:0] inv_r2c0,
    output logic signed [ELEM_WIDTH-1:0] inv_r0c1,
    output logic signed [ELEM_WIDTH-1:0] inv_r1c1,
    output logic signed [ELEM_WIDTH-1:0] inv_r2c1,
    output logic signed [ELEM_WIDTH-1:0] inv_r0c2,
    output logic signed [ELEM_WIDTH-1:0] inv_r1c2,
    output logic signed [ELEM_WIDTH-1:0] inv_r2c2,
    output logic signed [ELEM_WIDTH-1:0] det_value,
    output logic                         singular
);

    localparam int LATENCY = ELEM_WIDTH + FIXED_STAGES;

    // The valid bit of each stage moves with its data; the data path itself
    // advances every cycle because nothing downstream can stall it.
    logic [LATENCY-1:0] valid_reg;
    logic [LATENCY-1:0] valid_next;
    logic               item_accept;

    logic signed [ELEM_WIDTH-1:0]   elem_reg [NUM_ELEMS];
    logic signed [2*ELEM_WIDTH:0]   cof [NUM_ELEMS];
    logic signed [ELEM_WIDTH-1:0]   det_elem [NUM_DET_TERMS];
    logic signed [3*ELEM_WIDTH+2:0] det;
    logic signed [2*ELEM_WIDTH:0]   cof_aligned [NUM_ELEMS];
    logic signed [ELEM_WIDTH-1:0]   inv [NUM_ELEMS];

    assign busy        = 1'b0;
    assign item_accept = start && !busy;
    assign valid_next  = {valid_reg[LATENCY-2:0], item_accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Input register; element order matches the column-by-column port list.
    always_ff @(posedge clk)
    begin
        elem_reg[0] <= a_r0c0;
        elem_reg[1] <= a_r1c0;
        elem_reg[2] <= a_r2c0;
        elem_reg[3] <= a_r0c1;
        elem_reg[4] <= a_r1c1;
        elem_reg[5] <= a_r2c1;
        elem_reg[6] <= a_r0c2;
        elem_reg[7] <= a_r1c2;
        elem_reg[8] <= a_r2c2;
    end

    // Exact cofactors: two products, then their difference.
    mi3_cofactor #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_cofactor (
        .clk      (clk),
        .elem     (elem_reg),
        .cof      (cof),
        .det_elem (det_elem)
    );

    // Exact determinant along row 0, with the cofactors delayed to match.
    mi3_determinant #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_determinant (
        .clk      (clk),
        .cof      (cof),
        .det_elem (det_elem),
        .det      (det),
        .cof_out  (cof_aligned)
    );

    // Nine quotient lanes sharing one divisor pipeline, plus saturation.
    mi3_divider #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_divider (
        .clk       (clk),
        .cof       (cof_aligned),
        .det       (det),
        .inv       (inv),
        .det_value (det_value),
        .singular  (singular)
    );

    assign done     = valid_reg[LATENCY-1];
    assign inv_r0c0 = inv[0];
    assign inv_r1c0 = inv[1];
    assign inv_r2c0 = inv[2];
    assign inv_r0c1 = inv[3];
    assign inv_r1c1 = inv[4];
    assign inv_r2c1 = inv[5];
    assign inv_r0c2 = inv[6];
    assign inv_r1c2 = inv[7];
    assign inv_r2c2 = inv[8];

endmodule

### design/mi3_checker.sv
`include "matrix_inverse_3x3_macros.svh"

module mi3_checker
    import mi3_pkg::*;
#(
    parameter int ELEM_WIDTH = 32
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic signed [ELEM_WIDTH-1:0] inv_r0c0,
    input logic signed [ELEM_WIDTH-1:0] inv_r1c0,
    input logic signed [ELEM_WIDTH-1:0] inv_r2c0,
    input logic signed [ELEM_WIDTH-1:0] inv_r0c1,
    input logic signed [ELEM_WIDTH-1:0] inv_r1c1,
    input logic signed [ELEM_WIDTH-1:0] inv_r2c1,
    input logic signed [ELEM_WIDTH-1:0] inv_r0c2,
    input logic signed [ELEM_WIDTH-1:0] inv_r1c2,
    input logic signed [ELEM_WIDTH-1:0] inv_r2c2,
    input logic signed [ELEM_WIDTH-1:0] det_value,
    input logic                         singular
);

    localparam int LATENCY = ELEM_WIDTH + FIXED_STAGES;

    logic item_in;
    logic out_all_zero;

    assign item_in      = start && !busy;
    assign out_all_zero = (inv_r0c0 == '0) && (inv_r1c0 == '0) && (inv_r2c0 == '0)
                       && (inv_r0c1 == '0) && (inv_r1c1 == '0) && (inv_r2c1 == '0)
                       && (inv_r0c2 == '0) && (inv_r1c2 == '0) && (inv_r2c2 == '0)
                       && (det_value == '0);

    // Every accepted item produces its result after the fixed latency.
    `MI3_ASSERT(a_result_follows, item_in |-> ##LATENCY done, "item lost in pipeline")

    // No result appears without an item accepted exactly one latency earlier.
    `MI3_ASSERT(a_no_phantom, done |-> $past(item_in, LATENCY), "result without item")

    // A singular result carries an all-zero inverse and determinant.
    `MI3_ASSERT(a_singular_zero, (done && singular) |-> out_all_zero, "singular result not zero")

    // The pipeline can take an item in every cycle; busy never rises.
    `MI3_ASSERT_NEXT(a_never_busy, 1'b1, !busy, "busy raised")

endmodule

bind matrix_inverse_3x3 mi3_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_mi3_checker (.*);

### dv/tb.sv
module tb;
    import mi3_pkg::*;

    localparam int EW        = 32;
    localparam int FB        = 16;
    // Wide enough for the exact determinant, 3*EW + 3 bits, with room.
    localparam int WIDE      = 200;
    localparam int N_RANDOM  = 2000;
    localparam int IDLE_MAX  = 4000;
    localparam int DRAIN     = 60;

    typedef logic signed [EW-1:0]   elem_t;
    typedef logic signed [WIDE-1:0] wide_t;
    typedef elem_t                  mat_t [NUM_ELEMS];

    typedef struct {
        elem_t inv [NUM_ELEMS];
        elem_t det;
        logic  sing;
    } inverse_t;

    localparam wide_t SAT_HI = 200'sd2147483647;
    localparam wide_t SAT_LO = -200'sd2147483648;

    // The scoreboard works out the inverse of each accepted matrix and keeps
    // the expected results in arrival order, since the block cannot reorder.
    class inverse_scoreboard;
        inverse_t pending [$];
        int       mismatches = 0;
        int       unexpected = 0;

        function automatic elem_t clamp(wide_t v);
            if (v > SAT_HI) return elem_t'(SAT_HI[EW-1:0]);
            if (v < SAT_LO) return elem_t'(SAT_LO[EW-1:0]);
            return v[EW-1:0];
        endfunction

        function automatic inverse_t compute_inverse(mat_t m);
            inverse_t r;
            wide_t e [NUM_ELEMS];
            wide_t cof [NUM_ELEMS];
            wide_t det, den, num, quo;
            for (int i = 0; i < NUM_ELEMS; i++) e[i] = m[i];
            for (int k = 0; k < NUM_ELEMS; k++)
                cof[k] = e[COF_IDX[k][0]] * e[COF_IDX[k][1]]
                       - e[COF_IDX[k][2]] * e[COF_IDX[k][3]];
            det = e[0] * cof[0] + e[3] * cof[1] + e[6] * cof[2];
            r.sing = (det == 0);
            if (r.sing) begin
                for (int k = 0; k < NUM_ELEMS; k++) r.inv[k] = '0;
                r.det = '0;
                return r;
            end
            den = (det < 0) ? -det : det;
            for (int k = 0; k < NUM_ELEMS; k++) begin
                num = ((cof[k] < 0) ? -cof[k] : cof[k]) <<< (2 * FB);
                // Magnitudes divide, so the quotient truncates toward zero.
                quo = num / den;
                if ((cof[k] < 0) != (det < 0)) quo = -quo;
                r.inv[k] = clamp(quo);
            end
            r.det = clamp(det >>> (2 * FB));
            return r;
        endfunction

        function void note(mat_t m);
            pending.push_back(compute_inverse(m));
        endfunction

        function void check(inverse_t got);
            inverse_t want;
            bit bad;
            if (pending.size() == 0) begin
                unexpected++;
                $display("result arrived with no matrix outstanding");
                return;
            end
            want = pending.pop_front();
            bad = (got.det !== want.det) || (got.sing !== want.sing);
            for (int k = 0; k < NUM_ELEMS; k++)
                if (got.inv[k] !== want.inv[k]) bad = 1;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: singular exp %0b got %0b, det exp %h got %h",
                             want.sing, got.sing, want.det, got.det);
                    for (int k = 0; k < NUM_ELEMS; k++)
                        $display("  inv[%0d] exp %h got %h", k, want.inv[k], got.inv[k]);
                end
            end
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    logic  done;
    logic  singular;
    elem_t a [NUM_ELEMS];
    elem_t inv [NUM_ELEMS];
    elem_t det_value;

    inverse_scoreboard sb;
    int idle_cycles;

    matrix_inverse_3x3 u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .a_r0c0   (a[0]),
        .a_r1c0   (a[1]),
        .a_r2c0   (a[2]),
        .a_r0c1   (a[3]),
        .a_r1c1   (a[4]),
        .a_r2c1   (a[5]),
        .a_r0c2   (a[6]),
        .a_r1c2   (a[7]),
        .a_r2c2   (a[8]),
        .done     (done),
        .inv_r0c0 (inv[0]),
        .inv_r1c0 (inv[1]),
        .inv_r2c0 (inv[2]),
        .inv_r0c1 (inv[3]),
        .inv_r1c1 (inv[4]),
        .inv_r2c1 (inv[5]),
        .inv_r0c2 (inv[6]),
        .inv_r1c2 (inv[7]),
        .inv_r2c2 (inv[8]),
        .det_value(det_value),
        .singular (singular)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Both monitors sample at the rising edge, before the driver's
    // nonblocking updates of that edge take effect, so they see exactly the
    // values that the block itself latches.
    always @(posedge clk)
    begin
        inverse_t got;
        if (rst_n) begin
            if (start && !busy) sb.note(a);
            if (done) begin
                got.inv  = inv;
                got.det  = det_value;
                got.sing = singular;
                sb.check(got);
            end
            // The watchdog only counts cycles in which nothing moves.
            if ((start && !busy) || done) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_MAX) begin
            $display("[matrix_inverse_3x3] ERROR");
            $finish;
        end
    end

    // Present one matrix and hold it until the block takes it. Start stays
    // high on return, so back-to-back items never drop it within one step.
    task automatic send_matrix(mat_t m);
        start <= 1'b1;
        for (int i = 0; i < NUM_ELEMS; i++) a[i] <= m[i];
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic elem_t q16(int units);
        return elem_t'(units <<< FB);
    endfunction

    function automatic elem_t rand_elem();
        case ($urandom_range(0, 9))
            0, 1:    return elem_t'($urandom);
            2:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            3:       return elem_t'($signed($urandom_range(0, 16)) - 8);
            4, 5, 6: return q16($signed($urandom_range(0, 16)) - 8)
                            + elem_t'($signed($urandom_range(0, 65535)) - 32768);
            default: return elem_t'($signed($urandom_range(0, 2097151)) - 1048576);
        endcase
    endfunction

    function automatic mat_t rand_matrix();
        mat_t m;
        int src, dst, mul;
        for (int i = 0; i < NUM_ELEMS; i++) m[i] = rand_elem();
        // About one in six is made rank deficient: one row copies a small
        // multiple of another, which drives the exact determinant to zero.
        if ($urandom_range(0, 5) == 0) begin
            src = $urandom_range(0, 2);
            dst = (src + 1 + $urandom_range(0, 1)) % 3;
            mul = $signed($urandom_range(0, 6)) - 3;
            for (int c = 0; c < 3; c++) begin
                m[3*c + src] = elem_t'($signed($urandom_range(0, 65535)) - 32768);
                m[3*c + dst] = m[3*c + src] * mul;
            end
        end
        return m;
    endfunction

    function automatic mat_t diag(elem_t d0, elem_t d1, elem_t d2);
        mat_t m;
        for (int i = 0; i < NUM_ELEMS; i++) m[i] = '0;
        m[0] = d0;
        m[4] = d1;
        m[8] = d2;
        return m;
    endfunction

    initial
    begin
        mat_t m;
        int burst;
        sb          = new();
        idle_cycles = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        for (int i = 0; i < NUM_ELEMS; i++) a[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the zero matrix and other singular cases, identity,
        // signs, both element extremes, a tiny determinant that still shows
        // as zero, and inverses that saturate both ways.
        send_matrix(diag('0, '0, '0));
        send_matrix(diag(q16(1), q16(1), q16(1)));
        send_matrix(diag(q16(-1), q16(2), q16(-4)));
        send_matrix(diag(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        send_matrix(diag(32'sh80000000, 32'sh80000000, 32'sh80000000));
        send_matrix(diag(32'sh80000000, 32'sh7fffffff, 32'sh80000000));
        send_matrix(diag(32'sd1, 32'sd1, 32'sd1));
        send_matrix(diag(32'sd1, q16(1), q16(1)));
        send_matrix(diag(-32'sd1, q16(-1), q16(1)));
        send_matrix(diag(q16(1), q16(1), '0));
        pause(3);
        for (int i = 0; i < NUM_ELEMS; i++) m[i] = 32'sh7fffffff;
        send_matrix(m);
        for (int i = 0; i < NUM_ELEMS; i++) m[i] = 32'sh80000000;
        send_matrix(m);
        for (int i = 0; i < NUM_ELEMS; i++) m[i] = (i % 2) ? 32'sh80000000 : 32'sh7fffffff;
        send_matrix(m);
        for (int i = 0; i < NUM_ELEMS; i++) m[i] = q16(i + 1);
        send_matrix(m);
        m = diag('0, '0, '0);
        m[1] = q16(1);
        m[3] = q16(1);
        m[8] = q16(1);
        send_matrix(m);
        m = diag(q16(2), q16(3), q16(5));
        m[6] = q16(-7);
        m[5] = 32'sh00008000;
        send_matrix(m);
        for (int i = 0; i < NUM_ELEMS; i++) m[i] = 32'shffffffff;
        send_matrix(m);
        pause(2);

        // Random part: bursts of back-to-back items, gaps of random length,
        // and now and then a long gap so the pipeline drains completely.
        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++)
                send_matrix(rand_matrix());
            if ($urandom_range(0, 15) == 0) pause($urandom_range(40, 60));
            else if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending.size() == 0)
            $display("[matrix_inverse_3x3] OK");
        else
            $display("[matrix_inverse_3x3] ERROR");
        $finish;
    end
endmodule

### sim.f
+incdir+design
design/mi3_pkg.sv
design/mi3_cofactor.sv
design/mi3_determinant.sv
design/mi3_divider.sv
design/matrix_inverse_3x3.sv
design/mi3_checker.sv
dv/tb.sv
